>>> rtl/pst_pkg.sv
// Package for the pitch target selector: constants, codes, state type,
// table entry and divider request/response structs. No dependencies.
`default_nettype none
package pst_pkg;

    localparam int SLOTS  = 32;
    localparam int SLOT_W = 5;
    localparam int CNT_W  = 6;

    localparam logic [0:0] OP_WRITE = 1'b0;
    localparam logic [0:0] OP_PITCH = 1'b1;

    localparam logic [2:0] CFG_PERIOD = 3'd0;
    localparam logic [2:0] CFG_ROOT   = 3'd1;
    localparam logic [2:0] CFG_COUNT  = 3'd2;
    localparam logic [2:0] CFG_DIR    = 3'd3;
    localparam logic [2:0] CFG_ARTIC  = 3'd4;
    localparam logic [2:0] CFG_ONPROT = 3'd5;
    localparam logic [2:0] CFG_HYST   = 3'd6;
    localparam logic [2:0] CFG_ALPHA  = 3'd7;

    localparam int DIV_NUM_W = 51;
    localparam int DIV_DEN_W = 25;
    localparam int DIV_Q_W   = 26;

    localparam logic signed [24:0] SCORE_MIN = -25'sd16777216;

    typedef enum logic [4:0] {
        S_IDLE, S_CDIV, S_CWAIT, S_MULP, S_PBASE, S_SLOT, S_G1, S_G2, S_G3,
        S_CAND, S_DWAIT, S_SCORE, S_WEND, S_T1, S_T2, S_T3, S_T4, S_HIST,
        S_HCHK, S_HRD, S_GLIDE0, S_GLIDE1, S_GLIDE2, S_OUT
    } t_state;

    typedef struct packed {
        logic signed [19:0] off;
        logic [16:0]        plain;
        logic [17:0]        rise;
        logic [17:0]        fall;
    } t_entry;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quo;
        logic               rem_nz;
    } t_div_rsp;

    function automatic logic signed [28:0] rnd16(input logic signed [44:0] x);
        logic signed [44:0] t;
        t = x + 45'sd32768;
        return t[44:16];
    endfunction

endpackage
`default_nettype wire

>>> rtl/pst_chan_if.sv
// Request channels of the pitch target selector: input items and results.
// Stand-alone; carries valid, ready and the payload fields.
`default_nettype none
interface pst_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [19:0] observed_cents;
    logic signed [21:0] motion_rate;
    logic [16:0]        confidence;
    logic [16:0]        onset_level;
    logic [4:0]         entry_index;
    logic signed [19:0] entry_cents;
    logic [16:0]        entry_gravity;
    logic [17:0]        entry_rise_gravity;
    logic [17:0]        entry_fall_gravity;
    logic               entry_enabled;
    modport source (output valid, op, observed_cents, motion_rate, confidence,
                    onset_level, entry_index, entry_cents, entry_gravity,
                    entry_rise_gravity, entry_fall_gravity, entry_enabled,
                    input ready);
    modport sink (input valid, op, observed_cents, motion_rate, confidence,
                  onset_level, entry_index, entry_cents, entry_gravity,
                  entry_rise_gravity, entry_fall_gravity, entry_enabled,
                  output ready);
endinterface

interface pst_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] glide_cents;
    logic signed [19:0] chosen_cents;
    logic [4:0]         chosen_degree;
    logic               degree_found;
    logic signed [24:0] chosen_score;
    logic               target_changed;
    logic [31:0]        change_total;
    modport source (output valid, glide_cents, chosen_cents, chosen_degree,
                    degree_found, chosen_score, target_changed, change_total,
                    input ready);
    modport sink (input valid, glide_cents, chosen_cents, chosen_degree,
                  degree_found, chosen_score, target_changed, change_total,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/pst_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pst_pkg for the request and response structs.
`default_nettype none
module pst_div
    import pst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_Q_W-1:0]   r_low;
    logic [DIV_Q_W-1:0]   r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    assign trial = {r_rem, r_low[DIV_Q_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_Q_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[DIV_NUM_W-1:DIV_Q_W];
            r_low <= i_req.num[DIV_Q_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
            r_low <= {r_low[DIV_Q_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_Q_W-2:0], ge};
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quo    = r_quo;
    assign o_rsp.rem_nz = r_rem != '0;
endmodule
`default_nettype wire

>>> rtl/pitch_target_selector_top.sv
// Top level of the pitch target selector: degree table, sequencer,
// shared multiplier. Depends on pst_pkg, pst_chan_if and pst_div.
//
//  channel | dir | request
//  i_in    | in  | op 0 degree write, op 1 pitch estimate
//  o_out   | out | one result per op 1
//  i_cfg_* | in  | register write, no handshake
//
// op 0 writes one table entry. Op 1 on an empty table goes straight to the
// result; otherwise op 1 walks the slots, and each of five candidates per
// enabled degree, and the held target when it is rescored, goes through the
// shared divider, but a candidate beyond capture range skips it.
// Reset sets config defaults, clears enables and held target; the table is not cleared.
// i_in is ready only when idle; a waiting result stalls the sequencer alone.
`default_nettype none
module pitch_target_selector_top
    import pst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pst_in_if.sink           i_in,
    pst_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [17:0] i_cfg_data
);
    t_state r_state, n_state;

    logic [16:0]        r_period, r_dir, r_onprot, r_hyst, r_alpha;
    logic signed [15:0] r_root;
    logic [5:0]         r_count;
    logic signed [17:0] r_artic;

    t_entry             mem [SLOTS];
    t_entry             r_mem_q;
    logic [SLOTS-1:0]   r_active;
    logic [SLOT_W-1:0]  rd_addr;

    logic signed [19:0] r_obs;
    logic signed [21:0] r_motion;
    logic [16:0]        r_conf, r_onset;

    logic signed [19:0] r_held_t;
    logic [SLOT_W-1:0]  r_held_d;
    logic               r_held_ok, r_tv;
    logic signed [23:0] r_glide;
    logic [31:0]        r_tally;

    logic [CNT_W-1:0]   r_slot;
    logic [2:0]         r_k;
    logic signed [18:0] r_center;
    logic signed [36:0] r_p0;
    logic [17:0]        r_grav;
    logic [24:0]        r_cap;
    logic signed [37:0] r_cand, r_best_t;
    logic signed [24:0] r_score, r_best_s;
    logic [SLOT_W-1:0]  r_best_d;
    logic               r_found, r_held_pass, r_release, r_changed;
    logic signed [44:0] r_prod;
    logic [16:0]        r_t1, r_hist;
    logic signed [19:0] r_res_glide;

    logic               r_o_valid;
    logic signed [19:0] r_o_glide, r_o_chosen;
    logic [4:0]         r_o_deg;
    logic               r_o_found, r_o_changed;
    logic signed [24:0] r_o_score;
    logic [31:0]        r_o_tally;

    logic               in_acc, out_free;
    logic [16:0]        period_eff, dirn, onprot_c, hyst_c, alpha_c, det;
    logic [5:0]         count_eff;
    logic signed [17:0] artic_c;
    logic signed [18:0] a_sum;
    logic signed [25:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [28:0] rnd_p;
    logic [17:0]        dir_sel, grav_c;
    logic signed [28:0] blend_w;
    logic [24:0]        cap_c;
    logic signed [20:0] cdiff;
    logic [20:0]        cabs;
    logic signed [19:0] cq;
    logic signed [38:0] ddiff;
    logic [37:0]        cand_dist;
    logic               sat;
    logic signed [26:0] sc;
    logic signed [19:0] thr;
    logic signed [24:0] gn;
    logic signed [24:0] g_rnd_now;
    logic signed [24:0] g_rnd_new;
    logic               hold_ok;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    pst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign out_free   = !r_o_valid || o_out.ready;

    assign period_eff = (r_period < 17'd16) ? 17'd16 : r_period;
    assign count_eff  = (r_count > 6'(SLOTS)) ? 6'(SLOTS) : r_count;
    assign dirn       = (r_dir > 17'd65536) ? 17'd65536 : r_dir;
    assign onprot_c   = (r_onprot > 17'd65536) ? 17'd65536 : r_onprot;
    assign hyst_c     = (r_hyst > 17'd65536) ? 17'd65536 : r_hyst;
    assign alpha_c    = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;
    assign artic_c    = (r_artic > 18'sd65536) ? 18'sd65536 :
                        (r_artic < -18'sd65536) ? -18'sd65536 : r_artic;
    assign a_sum      = 19'(artic_c) + 19'sd65536;
    assign det        = a_sum[17:1];

    assign rnd_p   = rnd16(r_prod);
    assign dir_sel = (r_motion > 22'sd96) ? r_mem_q.rise :
                     (r_motion < -22'sd96) ? r_mem_q.fall : 18'd65536;
    assign blend_w = 29'sd65536 + rnd_p;
    assign grav_c  = (rnd_p < 29'sd1311) ? 18'd1311 :
                     (rnd_p > 29'sd131072) ? 18'd131072 : rnd_p[17:0];
    assign cap_c   = 25'd2490368 + 25'(grav_c) * 25'd155;

    assign cdiff = 21'(r_obs) - 21'(r_root);
    assign cabs  = cdiff[20] ? 21'(-cdiff) : cdiff;
    assign cq    = cdiff[20] ? -($signed({1'b0, div_rsp.quo[18:0]}) +
                                 $signed({19'b0, div_rsp.rem_nz}))
                             : $signed({1'b0, div_rsp.quo[18:0]});

    assign ddiff     = 39'(r_cand) - 39'(r_obs);
    assign cand_dist = ddiff[38] ? 38'(-ddiff) : ddiff[37:0];
    assign sat       = {cand_dist, 2'b0} >= 40'(r_cap);
    assign sc        = $signed({9'b0, r_grav}) - $signed({1'b0, div_rsp.quo});

    assign thr = 20'sd11796 + $signed({3'b0, r_t1}) - 20'(rnd_p);

    assign gn        = 25'(r_glide) + 25'(rnd_p);
    assign g_rnd_now = 25'(r_glide) + 25'sd8;
    assign g_rnd_new = gn + 25'sd8;

    assign hold_ok = r_tv && !r_release && r_held_ok &&
                     ({1'b0, r_held_d} < count_eff) && r_active[r_held_d];

    assign rd_addr = r_held_pass ? r_held_d : r_slot[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 17'd19200;
            r_root   <= '0;
            r_count  <= '0;
            r_dir    <= '0;
            r_artic  <= '0;
            r_onprot <= '0;
            r_hyst   <= '0;
            r_alpha  <= 17'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD: r_period <= i_cfg_data[16:0];
                CFG_ROOT:   r_root   <= i_cfg_data[15:0];
                CFG_COUNT:  r_count  <= i_cfg_data[5:0];
                CFG_DIR:    r_dir    <= i_cfg_data[16:0];
                CFG_ARTIC:  r_artic  <= i_cfg_data;
                CFG_ONPROT: r_onprot <= i_cfg_data[16:0];
                CFG_HYST:   r_hyst   <= i_cfg_data[16:0];
                CFG_ALPHA:  r_alpha  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.op == OP_WRITE && {1'b0, i_in.entry_index} < 6'(SLOTS)) begin
            mem[i_in.entry_index] <= '{
                off:   i_in.entry_cents,
                plain: (i_in.entry_gravity > 17'd65536) ? 17'd65536 : i_in.entry_gravity,
                rise:  (i_in.entry_rise_gravity > 18'd131072) ? 18'd131072
                                                              : i_in.entry_rise_gravity,
                fall:  (i_in.entry_fall_gravity > 18'd131072) ? 18'd131072
                                                              : i_in.entry_fall_gravity
            };
        end
        r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.num   = 51'(cabs);
        div_req.den   = 25'(period_eff);
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.op == OP_PITCH) begin
                    n_state = (count_eff == '0) ? S_OUT : S_CDIV;
                end
            end
            S_CDIV: begin
                div_req.start = 1'b1;
                n_state       = S_CWAIT;
            end
            S_CWAIT: begin
                if (div_rsp.done) n_state = S_MULP;
            end
            S_MULP: begin
                mul_a   = 26'(r_center) - 26'sd2;
                mul_b   = $signed({2'b0, period_eff});
                n_state = S_PBASE;
            end
            S_PBASE: n_state = S_SLOT;
            S_SLOT: begin
                if (r_slot >= count_eff) n_state = S_WEND;
                else if (r_active[r_slot[SLOT_W-1:0]]) n_state = S_G1;
            end
            S_G1: begin
                mul_a   = $signed({8'b0, dir_sel}) - 26'sd65536;
                mul_b   = $signed({2'b0, dirn});
                n_state = S_G2;
            end
            S_G2: begin
                mul_a   = $signed({9'b0, r_mem_q.plain});
                mul_b   = blend_w[18:0];
                n_state = S_G3;
            end
            S_G3: n_state = S_CAND;
            S_CAND: begin
                if (sat) begin
                    n_state = S_SCORE;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = {cand_dist[22:0], 28'b0};
                    div_req.den   = r_cap;
                    n_state       = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (div_rsp.done) n_state = S_SCORE;
            end
            S_SCORE: begin
                if (r_held_pass) n_state = S_GLIDE0;
                else if (r_k == 3'd4) n_state = S_SLOT;
                else n_state = S_CAND;
            end
            S_WEND: n_state = r_found ? S_T1 : S_OUT;
            S_T1: begin
                mul_a   = 26'sd35390;
                mul_b   = $signed({2'b0, onprot_c});
                n_state = S_T2;
            end
            S_T2: begin
                mul_a   = 26'sd36045;
                mul_b   = $signed({2'b0, det});
                n_state = S_T3;
            end
            S_T3: begin
                mul_a   = 26'sd40632;
                mul_b   = $signed({2'b0, hyst_c});
                n_state = S_T4;
            end
            S_T4: begin
                mul_a   = 26'sd14418 + 26'(rnd_p);
                mul_b   = 19'sd65536 - $signed({2'b0, det});
                n_state = S_HIST;
            end
            S_HIST: n_state = S_HCHK;
            S_HCHK: n_state = hold_ok ? S_HRD : S_GLIDE0;
            S_HRD:  n_state = S_G1;
            S_GLIDE0: n_state = S_GLIDE1;
            S_GLIDE1: begin
                mul_a   = 26'($signed({r_best_t[19:0], 4'b0})) - 26'(r_glide);
                mul_b   = $signed({2'b0, alpha_c});
                n_state = S_GLIDE2;
            end
            S_GLIDE2: n_state = S_OUT;
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                r_obs       <= i_in.observed_cents;
                r_motion    <= i_in.motion_rate;
                r_conf      <= i_in.confidence;
                r_onset     <= i_in.onset_level;
                r_best_t    <= 38'(i_in.observed_cents);
                r_best_s    <= '0;
                r_best_d    <= '0;
                r_found     <= 1'b0;
                r_changed   <= 1'b0;
                r_held_pass <= 1'b0;
                r_res_glide <= r_tv ? g_rnd_now[23:4] : i_in.observed_cents;
            end
            S_CWAIT: r_center <= cq[18:0];
            S_MULP:  r_slot   <= '0;
            S_PBASE: r_p0     <= r_prod[36:0];
            S_SLOT: begin
                if (r_slot < count_eff && !r_active[r_slot[SLOT_W-1:0]]) begin
                    r_slot <= r_slot + 6'd1;
                end
            end
            S_G3: begin
                r_grav <= grav_c;
                r_cap  <= cap_c;
                r_k    <= '0;
                r_cand <= r_held_pass ? 38'(r_held_t)
                                      : 38'(r_root) + 38'(r_mem_q.off) + 38'(r_p0);
            end
            S_CAND: begin
                if (sat) r_score <= SCORE_MIN;
            end
            S_DWAIT: begin
                r_score <= (sc < 27'(SCORE_MIN)) ? SCORE_MIN : sc[24:0];
            end
            S_SCORE: begin
                if (r_held_pass) begin
                    if (27'(r_best_s) < 27'(r_score) + $signed({10'b0, r_hist})) begin
                        r_best_t <= 38'(r_held_t);
                        r_best_s <= r_score;
                        r_best_d <= r_held_d;
                    end
                end else begin
                    if (!r_found || r_score > r_best_s) begin
                        r_best_t <= r_cand;
                        r_best_s <= r_score;
                        r_best_d <= r_slot[SLOT_W-1:0];
                        r_found  <= 1'b1;
                    end
                    if (r_k == 3'd4) begin
                        r_slot <= r_slot + 6'd1;
                    end else begin
                        r_k    <= r_k + 3'd1;
                        r_cand <= r_cand + 38'($signed({1'b0, period_eff}));
                    end
                end
            end
            S_WEND: begin
                if (!r_found) begin
                    r_res_glide <= r_obs;
                end else if (r_best_t > 38'sd524287) begin
                    r_best_t <= 38'sd524287;
                end else if (r_best_t < -38'sd524288) begin
                    r_best_t <= -38'sd524288;
                end
            end
            S_T2: r_t1 <= rnd_p[16:0];
            S_T3: begin
                r_release <= ($signed({3'b0, r_onset}) >
                              ((thr < 20'sd1966) ? 20'sd1966 :
                               (thr > 20'sd60293) ? 20'sd60293 : thr)) &&
                             (r_conf > 17'd22938);
            end
            S_HIST: r_hist <= rnd_p[16:0];
            S_HCHK: begin
                if (hold_ok) r_held_pass <= 1'b1;
            end
            S_GLIDE0: r_changed <= !r_tv || (r_best_t != 38'(r_held_t));
            S_GLIDE2: r_res_glide <= g_rnd_new[23:4];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_held_t  <= '0;
            r_held_d  <= '0;
            r_held_ok <= 1'b0;
            r_glide   <= '0;
            r_tv      <= 1'b0;
            r_tally   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_acc && i_in.op == OP_WRITE && {1'b0, i_in.entry_index} < 6'(SLOTS)) begin
                r_active[i_in.entry_index] <= i_in.entry_enabled;
            end
            if (r_state == S_WEND && !r_found) begin
                r_held_t  <= r_obs;
                r_glide   <= {r_obs, 4'b0};
                r_held_ok <= 1'b0;
                r_tv      <= 1'b0;
            end
            if (r_state == S_GLIDE0) begin
                if (r_tv && (r_best_t != 38'(r_held_t))) r_tally <= r_tally + 32'd1;
                r_held_t  <= r_best_t[19:0];
                r_held_d  <= r_best_d;
                r_held_ok <= 1'b1;
                if (!r_tv) begin
                    r_glide <= {r_best_t[19:0], 4'b0};
                    r_tv    <= 1'b1;
                end
            end
            if (r_state == S_GLIDE2) r_glide <= gn[23:0];
            if (r_state == S_OUT && out_free) r_o_valid <= 1'b1;
            else if (o_out.valid && o_out.ready) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_glide   <= r_res_glide;
            r_o_chosen  <= r_best_t[19:0];
            r_o_deg     <= r_found ? r_best_d : '0;
            r_o_found   <= r_found;
            r_o_score   <= r_found ? r_best_s : '0;
            r_o_changed <= r_changed;
            r_o_tally   <= r_tally;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.glide_cents    = r_o_glide;
    assign o_out.chosen_cents   = r_o_chosen;
    assign o_out.chosen_degree  = r_o_deg;
    assign o_out.degree_found   = r_o_found;
    assign o_out.chosen_score   = r_o_score;
    assign o_out.target_changed = r_o_changed;
    assign o_out.change_total   = r_o_tally;
endmodule
`default_nettype wire

>>> test/pitch_target_selector_top_tb.sv
// Testbench for pitch_target_selector_top: directed and random requests checked
// against an in-bench predictor of the target choice. Depends on pst_pkg,
// pst_chan_if and the RTL of the selector.
`timescale 1ns / 100ps
`default_nettype none
module pitch_target_selector_top_tb;
    import pst_pkg::*;

    localparam longint ONE = 65536;
    localparam longint CYCLE_LIMIT = 12000000;

    typedef struct {
        logic               op;
        logic signed [19:0] obs;
        logic signed [21:0] motion;
        logic [16:0]        conf;
        logic [16:0]        onset;
        logic [4:0]         idx;
        logic signed [19:0] cents;
        logic [16:0]        grav;
        logic [17:0]        rise;
        logic [17:0]        fall;
        logic               en;
    } t_pitch_req;

    typedef struct {
        logic signed [19:0] glide;
        logic signed [19:0] chosen;
        logic [4:0]         degree;
        logic               found;
        logic signed [24:0] score;
        logic               changed;
        logic [31:0]        total;
    } t_target;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [17:0] cfg_data;

    pst_in_if  in_if ();
    pst_out_if out_if ();

    pitch_target_selector_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    longint deg_off [SLOTS];
    longint deg_plain [SLOTS];
    longint deg_rise [SLOTS];
    longint deg_fall [SLOTS];
    bit     deg_on [SLOTS];
    longint held_tgt;
    int     held_deg;
    bit     held_ok;
    longint glide_q8;
    bit     tgt_valid;
    bit [31:0] tally;
    longint r_period, r_root, r_count, r_dir, r_artic, r_onprot, r_hyst, r_alpha;

    t_target expected_targets[$];
    int      errors = 0;
    longint  cycles = 0;
    bit      idle_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** pitch_target_selector_top: FAILED **");
            $finish;
        end
    end

    function automatic longint rnd16(input longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic longint floor_div(input longint a, input longint b);
        if (a >= 0) return a / b;
        return -((-a + b - 1) / b);
    endfunction

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint degree_score(input longint cand, input int slot,
                                            input longint obs, input longint motion);
        longint dir, blend, grav, cap, gap, q;
        dir = ONE;
        if (motion > 96) dir = deg_rise[slot];
        else if (motion < -96) dir = deg_fall[slot];
        blend = ONE + rnd16((dir - ONE) * clip(r_dir, 0, ONE));
        grav = clip(rnd16(deg_plain[slot] * blend), 1311, 131072);
        cap = 38 * ONE + 155 * grav;
        gap = cand - obs;
        if (gap < 0) gap = -gap;
        q = (gap <<< 28) / cap;
        return clip(grav - q, -16777216, 16777215);
    endfunction

    function automatic bit choose_target(input t_pitch_req q, output t_target t);
        longint obs, motion, conf, onset, per, center, cand, s, bt, bs, glide_out, chosen;
        longint det, thr, ps, hist, score_out;
        int bd, cnt;
        bit found, changed, release_hold;
        if (q.op == OP_WRITE) begin
            deg_off[q.idx] = q.cents;
            deg_plain[q.idx] = clip(q.grav, 0, ONE);
            deg_rise[q.idx] = clip(q.rise, 0, 2 * ONE);
            deg_fall[q.idx] = clip(q.fall, 0, 2 * ONE);
            deg_on[q.idx] = q.en;
            return 1'b0;
        end
        obs = q.obs;
        motion = q.motion;
        conf = clip(q.conf, 0, ONE);
        onset = clip(q.onset, 0, ONE);
        cnt = r_count < SLOTS ? int'(r_count) : SLOTS;
        chosen = obs;
        glide_out = obs;
        bd = -1; bt = 0; bs = 0; score_out = 0; found = 0; changed = 0;
        if (cnt == 0) begin
            if (tgt_valid) glide_out = (glide_q8 + 8) >>> 4;
        end else begin
            per = r_period < 16 ? 16 : r_period;
            center = floor_div(obs - r_root, per);
            for (int i = 0; i < cnt; i++) begin
                if (deg_on[i]) begin
                    for (int k = -2; k <= 2; k++) begin
                        cand = r_root + deg_off[i] + (center + k) * per;
                        s = degree_score(cand, i, obs, motion);
                        if (bd < 0 || s > bs) begin
                            bs = s; bt = cand; bd = i;
                        end
                    end
                end
            end
            if (bd < 0) begin
                held_tgt = obs;
                glide_q8 = obs * 16;
                held_ok = 0;
                tgt_valid = 0;
            end else begin
                det = (clip(r_artic, -ONE, ONE) + ONE) / 2;
                thr = 11796 + rnd16(35390 * clip(r_onprot, 0, ONE)) - rnd16(36045 * det);
                thr = clip(thr, 1966, 60293);
                release_hold = onset > thr && conf > 22938;
                bt = clip(bt, -524288, 524287);
                if (tgt_valid && !release_hold && held_ok && held_deg < cnt
                        && deg_on[held_deg]) begin
                    ps = degree_score(held_tgt, held_deg, obs, motion);
                    hist = rnd16((ONE - det) * (14418 + rnd16(40632 * clip(r_hyst, 0, ONE))));
                    if (bs < ps + hist) begin
                        bt = held_tgt; bs = ps; bd = held_deg;
                    end
                end
                changed = !tgt_valid || bt != held_tgt;
                if (changed && tgt_valid) tally++;
                held_tgt = bt;
                held_deg = bd;
                held_ok = 1;
                if (!tgt_valid) begin
                    glide_q8 = bt * 16;
                    tgt_valid = 1;
                end
                glide_q8 += rnd16((bt * 16 - glide_q8) * clip(r_alpha, 0, ONE));
                glide_out = (glide_q8 + 8) >>> 4;
                chosen = bt;
                score_out = bs;
                found = 1;
            end
        end
        t.glide = glide_out[19:0];
        t.chosen = chosen[19:0];
        t.degree = found ? bd[4:0] : 5'd0;
        t.found = found;
        t.score = score_out[24:0];
        t.changed = changed;
        t.total = tally;
        return 1'b1;
    endfunction

    always @(negedge i_clk) begin
        out_if.ready <= !idle_on || ($urandom_range(99) >= 19);
    end

    always @(posedge i_clk) begin
        t_target e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_targets.size() == 0) begin
                $display("%0t unexpected result glide %0d", $time, out_if.glide_cents);
                errors++;
            end else begin
                e = expected_targets.pop_front();
                if (out_if.glide_cents !== e.glide || out_if.chosen_cents !== e.chosen ||
                        out_if.chosen_degree !== e.degree || out_if.degree_found !== e.found ||
                        out_if.chosen_score !== e.score ||
                        out_if.target_changed !== e.changed ||
                        out_if.change_total !== e.total) begin
                    $display("%0t mismatch expected glide %0d cents %0d deg %0d found %0d",
                             $time, e.glide, e.chosen, e.degree, e.found);
                    $display("    score %0d changed %0d total %0d", e.score, e.changed, e.total);
                    $display("%0t actual   glide %0d cents %0d deg %0d found %0d",
                             $time, out_if.glide_cents, out_if.chosen_cents,
                             out_if.chosen_degree, out_if.degree_found);
                    $display("    score %0d changed %0d total %0d", out_if.chosen_score,
                             out_if.target_changed, out_if.change_total);
                    errors++;
                end
            end
        end
    end

    task automatic send_req(input t_pitch_req q);
        t_target t;
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 19) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.op = q.op;
        in_if.observed_cents = q.obs;
        in_if.motion_rate = q.motion;
        in_if.confidence = q.conf;
        in_if.onset_level = q.onset;
        in_if.entry_index = q.idx;
        in_if.entry_cents = q.cents;
        in_if.entry_gravity = q.grav;
        in_if.entry_rise_gravity = q.rise;
        in_if.entry_fall_gravity = q.fall;
        in_if.entry_enabled = q.en;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        if (choose_target(q, t)) expected_targets.push_back(t);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_targets.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input longint d);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = d[17:0];
        @(posedge i_clk);
        case (idx)
            CFG_PERIOD: r_period = d[16:0];
            CFG_ROOT:   r_root = longint'($signed(d[15:0]));
            CFG_COUNT:  r_count = d[5:0];
            CFG_DIR:    r_dir = d[16:0];
            CFG_ARTIC:  r_artic = longint'($signed(d[17:0]));
            CFG_ONPROT: r_onprot = d[16:0];
            CFG_HYST:   r_hyst = d[16:0];
            CFG_ALPHA:  r_alpha = d[16:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic put_degree(input int idx, input longint cents, input longint g,
                              input longint r, input longint f, input bit en);
        t_pitch_req q;
        q = '{default: '0};
        q.op = OP_WRITE;
        q.idx = idx[4:0];
        q.cents = cents[19:0];
        q.grav = g[16:0];
        q.rise = r[17:0];
        q.fall = f[17:0];
        q.en = en;
        q.obs = 20'($urandom());
        q.motion = 22'($urandom());
        send_req(q);
    endtask

    task automatic put_pitch(input longint obs, input longint motion,
                             input longint conf, input longint onset);
        t_pitch_req q;
        q = '{default: '0};
        q.op = OP_PITCH;
        q.obs = obs[19:0];
        q.motion = motion[21:0];
        q.conf = conf[16:0];
        q.onset = onset[16:0];
        q.idx = 5'($urandom());
        q.cents = 20'($urandom());
        q.grav = 17'($urandom());
        q.rise = 18'($urandom());
        q.fall = 18'($urandom());
        q.en = 1'($urandom());
        send_req(q);
    endtask

    function automatic longint pick(input longint lo, input longint hi);
        return lo + longint'($urandom_range(int'(hi - lo)));
    endfunction

    task automatic test_empty_table();
        put_pitch(-524288, 0, 0, 0);
        put_pitch(524287, 2097151, 131071, 131071);
        put_pitch(384000, -2097152, 65536, 65536);
    endtask

    task automatic test_directed();
        drain();
        cfg_write(CFG_COUNT, 3);
        cfg_write(CFG_DIR, 65536);
        cfg_write(CFG_ARTIC, 18'h20000);
        cfg_write(CFG_ONPROT, 131071);
        cfg_write(CFG_HYST, 131071);
        cfg_write(CFG_ALPHA, 0);
        put_degree(0, 0, 131071, 262143, 0, 1);
        put_degree(1, 11200, 0, 0, 262143, 1);
        put_degree(2, -384000, 65536, 131072, 131072, 0);
        put_pitch(0, 0, 65536, 0);
        put_pitch(500, 97, 65536, 0);
        put_pitch(11000, -97, 65536, 0);
        put_pitch(11000, 96, 131071, 131071);
        put_pitch(-96, -96, 65536, 65536);
        put_pitch(524287, 1600000, 65536, 0);
        put_pitch(-524288, -1600000, 0, 65536);
        drain();
        cfg_write(CFG_ARTIC, 131071);
        cfg_write(CFG_ONPROT, 0);
        cfg_write(CFG_HYST, 0);
        cfg_write(CFG_ALPHA, 131071);
        cfg_write(CFG_PERIOD, 0);
        cfg_write(CFG_ROOT, 16'h8000);
        put_pitch(3, 0, 65536, 65536);
        put_pitch(-7000, 0, 22939, 65536);
        drain();
        cfg_write(CFG_PERIOD, 131071);
        cfg_write(CFG_ROOT, 19200);
        cfg_write(CFG_COUNT, 63);
        put_pitch(100000, 0, 65536, 0);
        put_degree(0, 0, 0, 0, 0, 0);
        put_degree(1, 0, 0, 0, 0, 0);
        put_pitch(-384000, 0, 65536, 0);
        put_pitch(384000, 200, 65536, 0);
    endtask

    task automatic random_config(input bit wide, input int cnt);
        cfg_write(CFG_PERIOD, wide && $urandom_range(3) == 0 ?
                  ($urandom_range(1) ? 131071 : $urandom_range(15)) : pick(800, 38400));
        cfg_write(CFG_ROOT, wide && $urandom_range(3) == 0 ? $urandom() : pick(-19200, 19200));
        cfg_write(CFG_COUNT, cnt);
        cfg_write(CFG_DIR, wide && $urandom_range(3) == 0 ? $urandom() : pick(0, ONE));
        cfg_write(CFG_ARTIC, wide && $urandom_range(3) == 0 ? $urandom() : pick(-ONE, ONE));
        cfg_write(CFG_ONPROT, wide && $urandom_range(3) == 0 ? $urandom() : pick(0, ONE));
        cfg_write(CFG_HYST, wide && $urandom_range(3) == 0 ? $urandom() : pick(0, ONE));
        cfg_write(CFG_ALPHA, wide && $urandom_range(3) == 0 ? $urandom() : pick(0, ONE));
    endtask

    task automatic test_random(input int phases);
        int cnt, walk, n, s;
        longint obs;
        for (int p = 0; p < phases; p++) begin
            drain();
            cnt = (p % 6 == 5) ? ($urandom_range(1) ? 32 : 63) : $urandom_range(1, 6);
            walk = cnt < SLOTS ? cnt : SLOTS;
            random_config(p % 2, cnt);
            for (int i = 0; i < walk; i++)
                put_degree(i, $urandom_range(9) == 0 ? pick(-524288, 524287) : pick(0, 19200),
                           $urandom_range(9) == 0 ? $urandom() : pick(0, ONE),
                           $urandom_range(9) == 0 ? $urandom() : pick(0, 2 * ONE),
                           $urandom_range(9) == 0 ? $urandom() : pick(0, 2 * ONE),
                           $urandom_range(9) != 0);
            n = walk > 8 ? 12 : 90;
            for (int k = 0; k < n; k++) begin
                s = $urandom_range(walk - 1);
                if ($urandom_range(19) == 0) begin
                    put_degree($urandom_range(walk - 1), pick(-524288, 524287), $urandom(),
                               $urandom(), $urandom(), $urandom_range(3) != 0);
                end else begin
                    if ($urandom_range(9) == 0)
                        obs = pick(-524288, 524287);
                    else
                        obs = clip(r_root + deg_off[s] + pick(-3, 3) * r_period + pick(-600, 600),
                                   -524288, 524287);
                    put_pitch(obs, $urandom_range(7) == 0 ? pick(-2097152, 2097151)
                                                          : pick(-400, 400),
                              $urandom_range(7) == 0 ? $urandom() : pick(0, ONE),
                              $urandom_range(3) == 0 ? $urandom() : pick(0, ONE / 4));
                end
            end
        end
    endtask

    task automatic test_pause_and_burst();
        drain();
        idle_on = 1'b0;
        random_config(0, 2);
        put_degree(0, 0, ONE, ONE, ONE, 1);
        put_degree(1, 3200, ONE / 2, ONE, ONE, 1);
        for (int k = 0; k < 60; k++) begin
            put_pitch(pick(-2000, 5000), pick(-300, 300), pick(0, ONE), pick(0, ONE));
            if (k == 30) drain();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_PERIOD;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.op = OP_PITCH;
        in_if.observed_cents = '0;
        in_if.motion_rate = '0;
        in_if.confidence = '0;
        in_if.onset_level = '0;
        in_if.entry_index = '0;
        in_if.entry_cents = '0;
        in_if.entry_gravity = '0;
        in_if.entry_rise_gravity = '0;
        in_if.entry_fall_gravity = '0;
        in_if.entry_enabled = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            deg_off[i] = 0; deg_plain[i] = 0; deg_rise[i] = 0; deg_fall[i] = 0;
            deg_on[i] = 0;
        end
        held_tgt = 0; held_deg = 0; held_ok = 0; glide_q8 = 0; tgt_valid = 0; tally = 0;
        r_period = 19200; r_root = 0; r_count = 0; r_dir = 0; r_artic = 0;
        r_onprot = 0; r_hyst = 0; r_alpha = ONE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_directed();
        test_random(14);
        test_pause_and_burst();

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("** pitch_target_selector_top: PASSED **");
        else
            $display("** pitch_target_selector_top: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
